// ----- rtl/core/periodic_cell_list_neighbor_search_assert.svh -----
// Assertion macros shared by the neighbor search checker.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef PERIODIC_CELL_LIST_NEIGHBOR_SEARCH_ASSERT_SVH
`define PERIODIC_CELL_LIST_NEIGHBOR_SEARCH_ASSERT_SVH

// same-cycle implication, off during reset
`define PCL_AST_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define PCL_AST_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// next-cycle implication, checked during reset too
`define PCL_AST_ALW(lbl, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/pcl_pkg.sv -----
// Package for the periodic cell-list neighbor search: codes, defaults, states.
// No dependencies.
`timescale 1ns / 1ps

package pcl_pkg;

  // default sizes
  localparam int MAX_PARTICLES_DEF  = 1024;
  localparam int CELLS_PER_AXIS_DEF = 16;
  localparam int COORD_BITS_DEF     = 16;

  // commands
  localparam logic [1:0] CMD_PARTICLE = 2'd0;
  localparam logic [1:0] CMD_HEAD     = 2'd1;
  localparam logic [1:0] CMD_QUERY    = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_HIT      = 2'd0;
  localparam logic [1:0] STAT_DONE     = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  // register indexes
  localparam logic REG_RADIUS_SQ = 1'b0;
  localparam logic REG_MAX_HITS  = 1'b1;

  localparam logic [5:0] MAX_HITS_RST = 6'd63;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL,
    S_HEAD,
    S_CHECK,
    S_READ,
    S_SQ,
    S_CMP,
    S_DONE
  } pcl_state_t;

endpackage

// ----- rtl/core/pcl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/periodic_cell_list_neighbor_search.sv -----
// Query: each of the 27 cells passes CELL, HEAD and CHECK, each chain particle READ, SQ
// (x, y, then z) and CMP; DONE gives the final beat. The chain walk through the position
// and link memories (one read a step, one shared squarer for x, y and z in turn) sets the
// query time. Overflow ends the walk, its beat in the cycle after the offending hit.
// Handshake: busy drops as the final beat goes out; writes give no results.
// Reset: synchronous; a pass over all cells^3 head entries sets every cell head empty, busy high.
`timescale 1ns / 1ps

module periodic_cell_list_neighbor_search #(
  parameter int MAX_PARTICLES  = pcl_pkg::MAX_PARTICLES_DEF,
  parameter int CELLS_PER_AXIS = pcl_pkg::CELLS_PER_AXIS_DEF,
  parameter int COORD_BITS     = pcl_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [11:0]        index,
  input  logic [15:0]        pos_x,
  input  logic [15:0]        pos_y,
  input  logic [15:0]        pos_z,
  input  logic signed [10:0] link,
  input  logic signed [10:0] min_index,
  // results
  output logic               strobe,
  output logic [1:0]         status,
  output logic [9:0]         particle,
  output logic [31:0]        dist_sq,
  output logic [5:0]         hit_count,
  output logic               last,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CB        = COORD_BITS;
  localparam int N         = CELLS_PER_AXIS;
  localparam int NUM_CELLS = N * N * N;
  localparam int PW        = $clog2(MAX_PARTICLES);
  localparam int CLW       = $clog2(NUM_CELLS);
  localparam int CW        = $clog2(N);
  localparam int SW        = PW + 1;
  localparam int AW        = 2 * CB + 2;
  localparam int RW        = (AW > 32) ? AW : 32;
  localparam int MW        = CB + CW + 1;

  // state and registers
  pcl_pkg::pcl_state_t state, state_next;

  logic [31:0]           radius_sq;
  logic [5:0]            max_hits;
  logic [CLW-1:0]        clr_addr;
  logic [CB-1:0]         qx, qy, qz;
  logic signed [10:0]    pmin;
  logic [CW-1:0]         cx, cy, cz;
  logic [1:0]            ox, oy, oz;
  logic signed [10:0]    p;
  logic signed [10:0]    nxt;
  logic [SW-1:0]         steps;
  logic [CB-1:0]         dx, dy, dz;
  logic [1:0]            sq_cnt;
  logic [AW-1:0]         acc;
  logic [5:0]            hits;

  // memory ports
  logic                  head_we;
  logic [CLW-1:0]        head_waddr, head_raddr;
  logic [10:0]           head_wdata, head_rdata;
  logic                  part_we;
  logic [PW-1:0]         part_waddr, part_raddr;
  logic [3*CB-1:0]       pos_rdata;
  logic [10:0]           next_rdata;

  // decoded controls
  logic                  accept;
  logic                  p_ok;
  logic                  last_cell;
  logic                  hit;
  logic                  emit_hit, emit_ovf, emit_done;
  logic [CW:0]           tx, ty, tz;
  logic [CW-1:0]         wx, wy, wz;
  logic [CB-1:0]         sq_d;
  logic [2*CB-1:0]       sq;
  logic [CB-1:0]         rx, ry, rz;

  assign busy   = (state != pcl_pkg::S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  // config read
  always_comb begin
    if (paddr[2] == pcl_pkg::REG_MAX_HITS) begin
      prdata = {26'd0, max_hits};
    end else begin
      prdata = radius_sq;
    end
  end

  // wrapped neighbor cell, offsets 0..2 stand for -1..+1
  function automatic logic [CW-1:0] wrap_cell(input logic [CW:0] t);
    logic [CW:0] u;
    u = t - (CW+1)'(1);
    if (t == '0) begin
      wrap_cell = CW'(N - 1);
    end else if (u == (CW+1)'(N)) begin
      wrap_cell = '0;
    end else begin
      wrap_cell = CW'(u);
    end
  endfunction

  // minimum-image distance along one axis
  function automatic logic [CB-1:0] axis_dist(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB-1:0] d;
    logic [CB:0]   side;
    d    = (a > b) ? (a - b) : (b - a);
    side = {1'b1, {CB{1'b0}}};
    if ({1'b0, d} > (side >> 1)) begin
      axis_dist = CB'(side - {1'b0, d});
    end else begin
      axis_dist = d;
    end
  endfunction

  assign tx = (CW+1)'(cx) + (CW+1)'(ox);
  assign ty = (CW+1)'(cy) + (CW+1)'(oy);
  assign tz = (CW+1)'(cz) + (CW+1)'(oz);
  assign wx = wrap_cell(tx);
  assign wy = wrap_cell(ty);
  assign wz = wrap_cell(tz);

  assign p_ok      = !p[10] && (32'($unsigned(p)) < MAX_PARTICLES) &&
                     (steps < SW'(MAX_PARTICLES));
  assign last_cell = (ox == 2'd2) && (oy == 2'd2) && (oz == 2'd2);
  assign hit       = (p > pmin) && (RW'(acc) <= RW'(radius_sq));

  assign rx = CB'(pos_rdata[3*CB-1:2*CB]);
  assign ry = CB'(pos_rdata[2*CB-1:CB]);
  assign rz = CB'(pos_rdata[CB-1:0]);

  // shared squarer
  always_comb begin
    case (sq_cnt)
      2'd0:    sq_d = dx;
      2'd1:    sq_d = dy;
      default: sq_d = dz;
    endcase
  end
  assign sq = (2*CB)'(sq_d) * (2*CB)'(sq_d);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pcl_pkg::S_CLEAR: begin
        if (clr_addr == CLW'(NUM_CELLS - 1)) state_next = pcl_pkg::S_IDLE;
      end
      pcl_pkg::S_IDLE: begin
        if (accept && command == pcl_pkg::CMD_QUERY) state_next = pcl_pkg::S_CELL;
      end
      pcl_pkg::S_CELL:  state_next = pcl_pkg::S_HEAD;
      pcl_pkg::S_HEAD:  state_next = pcl_pkg::S_CHECK;
      pcl_pkg::S_CHECK: begin
        if (p_ok) begin
          state_next = pcl_pkg::S_READ;
        end else if (last_cell) begin
          state_next = pcl_pkg::S_DONE;
        end else begin
          state_next = pcl_pkg::S_CELL;
        end
      end
      pcl_pkg::S_READ:  state_next = pcl_pkg::S_SQ;
      pcl_pkg::S_SQ: begin
        if (sq_cnt == 2'd2) state_next = pcl_pkg::S_CMP;
      end
      pcl_pkg::S_CMP: begin
        if (hit && hits >= max_hits) begin
          state_next = pcl_pkg::S_IDLE;
        end else begin
          state_next = pcl_pkg::S_CHECK;
        end
      end
      pcl_pkg::S_DONE:  state_next = pcl_pkg::S_IDLE;
      default:          state_next = pcl_pkg::S_IDLE;
    endcase
  end

  // outputs of the controller: memory ports and result pulses
  always_comb begin
    head_we    = 1'b0;
    head_waddr = CLW'(index);
    head_wdata = link;
    head_raddr = CLW'((CLW'(wx) * CLW'(N) + CLW'(wy)) * CLW'(N) + CLW'(wz));
    part_we    = 1'b0;
    part_waddr = PW'(index);
    part_raddr = PW'($unsigned(p));
    emit_hit   = 1'b0;
    emit_ovf   = 1'b0;
    emit_done  = 1'b0;
    case (state)
      pcl_pkg::S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_addr;
        head_wdata = '1;
      end
      pcl_pkg::S_IDLE: begin
        if (accept && command == pcl_pkg::CMD_PARTICLE &&
            32'(index) < MAX_PARTICLES) begin
          part_we = 1'b1;
        end
        if (accept && command == pcl_pkg::CMD_HEAD && 32'(index) < NUM_CELLS) begin
          head_we = 1'b1;
        end
      end
      pcl_pkg::S_CMP: begin
        emit_ovf = hit && (hits >= max_hits);
        emit_hit = hit && (hits < max_hits);
      end
      pcl_pkg::S_DONE: begin
        emit_done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcl_pkg::S_CLEAR;
      clr_addr  <= '0;
      radius_sq <= '0;
      max_hits  <= pcl_pkg::MAX_HITS_RST;
      strobe    <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit_hit || emit_ovf || emit_done;
      if (state == pcl_pkg::S_CLEAR) clr_addr <= clr_addr + CLW'(1);
      if (psel && penable && pwrite) begin
        if (paddr[2] == pcl_pkg::REG_MAX_HITS) begin
          max_hits <= pwdata[5:0];
        end else begin
          radius_sq <= pwdata;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      pcl_pkg::S_IDLE: begin
        qx   <= CB'(pos_x);
        qy   <= CB'(pos_y);
        qz   <= CB'(pos_z);
        cx   <= CW'((MW'(CB'(pos_x)) * MW'(N)) >> CB);
        cy   <= CW'((MW'(CB'(pos_y)) * MW'(N)) >> CB);
        cz   <= CW'((MW'(CB'(pos_z)) * MW'(N)) >> CB);
        pmin <= min_index;
        ox   <= 2'd0;
        oy   <= 2'd0;
        oz   <= 2'd0;
        hits <= '0;
      end
      pcl_pkg::S_HEAD: begin
        p     <= head_rdata;
        steps <= '0;
      end
      pcl_pkg::S_CHECK: begin
        if (p_ok) begin
          steps <= steps + SW'(1);
        end else if (oz != 2'd2) begin
          oz <= oz + 2'd1;
        end else begin
          oz <= 2'd0;
          if (oy != 2'd2) begin
            oy <= oy + 2'd1;
          end else begin
            oy <= 2'd0;
            ox <= ox + 2'd1;
          end
        end
      end
      pcl_pkg::S_READ: begin
        dx     <= axis_dist(qx, rx);
        dy     <= axis_dist(qy, ry);
        dz     <= axis_dist(qz, rz);
        nxt    <= next_rdata;
        sq_cnt <= 2'd0;
        acc    <= '0;
      end
      pcl_pkg::S_SQ: begin
        acc    <= acc + AW'(sq);
        sq_cnt <= sq_cnt + 2'd1;
      end
      pcl_pkg::S_CMP: begin
        p <= nxt;
        if (emit_hit) hits <= hits + 6'd1;
      end
      default: begin
      end
    endcase
    // result beat
    if (emit_hit) begin
      status    <= pcl_pkg::STAT_HIT;
      particle  <= p[9:0];
      dist_sq   <= 32'(acc);
      hit_count <= '0;
      last      <= 1'b0;
    end else begin
      status    <= emit_ovf ? pcl_pkg::STAT_OVERFLOW : pcl_pkg::STAT_DONE;
      particle  <= '0;
      dist_sq   <= '0;
      hit_count <= hits;
      last      <= 1'b1;
    end
  end

  // cell heads
  pcl_ram #(.WIDTH(11), .DEPTH(NUM_CELLS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  // particle positions
  pcl_ram #(.WIDTH(3*CB), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk   (clk),
    .we    (part_we),
    .waddr (part_waddr),
    .wdata ({CB'(pos_x), CB'(pos_y), CB'(pos_z)}),
    .raddr (part_raddr),
    .rdata (pos_rdata)
  );

  // particle next links
  pcl_ram #(.WIDTH(11), .DEPTH(MAX_PARTICLES)) u_next_ram (
    .clk   (clk),
    .we    (part_we),
    .waddr (part_waddr),
    .wdata (link),
    .raddr (part_raddr),
    .rdata (next_rdata)
  );

endmodule

// ----- rtl/core/pcl_check.sv -----
// Port-level checker for the neighbor search, bound to the top level.
// Depends on pcl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "periodic_cell_list_neighbor_search_assert.svh"

module pcl_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] command,
  input logic       strobe,
  input logic [1:0] status,
  input logic       last
);

  // reset starts the head clearing pass
  `PCL_AST_ALW(a_rst_busy, rst, busy)
  // a query keeps the block busy
  `PCL_AST_NXT(a_query_busy, start && !busy && command == pcl_pkg::CMD_QUERY, busy)
  // final beat carries done or overflow
  `PCL_AST_IMP(a_last_stat, strobe && last,
               status == pcl_pkg::STAT_DONE || status == pcl_pkg::STAT_OVERFLOW)
  // other beats are hits
  `PCL_AST_IMP(a_hit_stat, strobe && !last, status == pcl_pkg::STAT_HIT)

endmodule

bind periodic_cell_list_neighbor_search pcl_check u_pcl_check (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .command (command),
  .strobe  (strobe),
  .status  (status),
  .last    (last)
);

// ----- tb/tb_periodic_cell_list_neighbor_search.sv -----
// Testbench for periodic_cell_list_neighbor_search: builds periodic cell lists, runs queries,
// and checks every result beat against an in-bench neighbor search predictor.
// Depends on pcl_pkg and the block RTL only.
`timescale 1ns / 1ps

module tb_periodic_cell_list_neighbor_search;

  localparam int NPART  = 1024;
  localparam int NCELL  = 4096;
  localparam int LIMIT  = 300000;
  localparam logic [31:0] RAD_MAX = 32'd3221225472;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [11:0]        idx;
    logic [15:0]        x, y, z;
    logic signed [10:0] lnk;
    logic signed [10:0] mn;
  } nbr_cmd_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [9:0]  part;
    logic [31:0] d2;
    logic [5:0]  cnt;
    logic        lst;
  } nbr_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command = '0;
  logic [11:0] index = '0;
  logic [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [10:0] link = '0, min_index = '0;
  logic strobe;
  logic [1:0] status;
  logic [9:0] particle;
  logic [31:0] dist_sq;
  logic [5:0] hit_count;
  logic last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  periodic_cell_list_neighbor_search u_top (.*);

  // predictor state
  logic [15:0] mdl_pos [NPART][3];
  logic signed [10:0] mdl_next [NPART];
  logic signed [10:0] mdl_head [NCELL];
  bit mdl_written [NPART];
  logic [31:0] mdl_radius;
  logic [5:0] mdl_max_hits;

  nbr_res_t expected_q[$];
  int errors, n_items, n_queries, n_hits, n_overflow, wd_count;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= 30) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic longint unsigned axis_gap(input logic [15:0] a, input logic [15:0] b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    if (d > 32768) d = 65536 - d;
    return d;
  endfunction

  // expected beats of one accepted command; state updates for writes
  function automatic void search_predict(input nbr_cmd_t c);
    int cx, cy, cz, p, steps, hits;
    longint unsigned r2;
    nbr_res_t r;
    if (c.cmd == pcl_pkg::CMD_PARTICLE) begin
      if (c.idx < NPART) begin
        mdl_pos[c.idx][0] = c.x;
        mdl_pos[c.idx][1] = c.y;
        mdl_pos[c.idx][2] = c.z;
        mdl_next[c.idx] = c.lnk;
        mdl_written[c.idx] = 1'b1;
      end
      return;
    end
    if (c.cmd == pcl_pkg::CMD_HEAD) begin
      mdl_head[c.idx] = c.lnk;
      return;
    end
    if (c.cmd != pcl_pkg::CMD_QUERY) return;
    cx = c.x >> 12;
    cy = c.y >> 12;
    cz = c.z >> 12;
    hits = 0;
    for (int ox = -1; ox <= 1; ox++)
      for (int oy = -1; oy <= 1; oy++)
        for (int oz = -1; oz <= 1; oz++) begin
          p = mdl_head[(((cx + ox + 16) % 16) * 16 + (cy + oy + 16) % 16) * 16
                       + (cz + oz + 16) % 16];
          steps = 0;
          while (p >= 0 && p < NPART && steps < NPART) begin
            steps++;
            if (p > int'(c.mn)) begin
              r2 = axis_gap(c.x, mdl_pos[p][0]) ** 2 + axis_gap(c.y, mdl_pos[p][1]) ** 2
                 + axis_gap(c.z, mdl_pos[p][2]) ** 2;
              if (r2 <= mdl_radius) begin
                if (hits >= mdl_max_hits) begin
                  r = '{pcl_pkg::STAT_OVERFLOW, 10'd0, 32'd0, 6'(hits), 1'b1};
                  expected_q.push_back(r);
                  return;
                end
                r = '{pcl_pkg::STAT_HIT, 10'(p), 32'(r2), 6'd0, 1'b0};
                expected_q.push_back(r);
                hits++;
              end
            end
            p = mdl_next[p];
          end
        end
    r = '{pcl_pkg::STAT_DONE, 10'd0, 32'd0, 6'(hits), 1'b1};
    expected_q.push_back(r);
  endfunction

  // one command beat, with a random gap ahead of it
  task automatic send_item(input nbr_cmd_t c);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= c.cmd;
    index <= c.idx;
    pos_x <= c.x;
    pos_y <= c.y;
    pos_z <= c.z;
    link <= c.lnk;
    min_index <= c.mn;
    do @(posedge clk); while (busy);
    search_predict(c);
    n_items++;
    if (c.cmd == pcl_pkg::CMD_QUERY) n_queries++;
  endtask

  // stop sending and let every expected beat drain
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == 3'd4) begin
      mdl_max_hits = data[5:0];
      if (prdata[5:0] !== mdl_max_hits) report($sformatf("max_hits read %0h", prdata));
    end else begin
      mdl_radius = data;
      if (prdata !== mdl_radius) report($sformatf("radius_sq read %0h", prdata));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] rad, input logic [5:0] mh);
    wait_idle();
    cfg_write(3'd4 * pcl_pkg::REG_RADIUS_SQ, rad);
    cfg_write(3'd4 * pcl_pkg::REG_MAX_HITS, {26'd0, mh});
  endtask

  function automatic nbr_cmd_t mk(input logic [1:0] c, input int idx, input int x, input int y,
                                  input int z, input int lnk, input int mn);
    nbr_cmd_t r;
    r = '{c, 12'(idx), 16'(x), 16'(y), 16'(z), 11'(lnk), 11'(mn)};
    return r;
  endfunction

  function automatic int cell_of(input logic [15:0] x, input logic [15:0] y,
                                 input logic [15:0] z);
    return ((x >> 12) * 16 + (y >> 12)) * 16 + (z >> 12);
  endfunction

  // extreme coordinates, box wrap, index filter, ignored writes, cyclic chain, overflow
  task automatic test_directed();
    set_config(RAD_MAX, 6'd63);
    send_item(mk(pcl_pkg::CMD_PARTICLE, 0, 0, 0, 0, -1, 0));
    send_item(mk(pcl_pkg::CMD_PARTICLE, 1023, 65535, 65535, 65535, 0, 1023));
    send_item(mk(pcl_pkg::CMD_HEAD, 4095, 0, 0, 0, 1023, 0));
    send_item(mk(pcl_pkg::CMD_QUERY, 0, 0, 0, 0, 0, -1));
    send_item(mk(pcl_pkg::CMD_QUERY, 4095, 65535, 65535, 65535, 0, 0));
    send_item(mk(pcl_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 1023));
    send_item(mk(2'd3, 4095, 65535, 65535, 65535, -1, -1));
    send_item(mk(pcl_pkg::CMD_PARTICLE, 4095, 123, 456, 789, 1023, 5));
    send_item(mk(pcl_pkg::CMD_HEAD, 2730, 0, 0, 0, -1, 0));
    // two-particle loop: the walk stops after the visit cap
    send_item(mk(pcl_pkg::CMD_PARTICLE, 2, 32768, 32768, 32768, 3, 0));
    send_item(mk(pcl_pkg::CMD_PARTICLE, 3, 32800, 32768, 32768, 2, 0));
    send_item(mk(pcl_pkg::CMD_HEAD, cell_of(16'd32768, 16'd32768, 16'd32768), 0, 0, 0, 2, 0));
    send_item(mk(pcl_pkg::CMD_QUERY, 0, 32768, 32768, 32768, 0, 1000));
    send_item(mk(pcl_pkg::CMD_QUERY, 0, 32768, 32768, 32768, 0, -1));
    set_config(RAD_MAX, 6'd1);
    send_item(mk(pcl_pkg::CMD_QUERY, 0, 0, 0, 0, 0, -1));
    set_config(32'd0, 6'd63);
    send_item(mk(pcl_pkg::CMD_QUERY, 0, 0, 0, 0, 0, -1));
    send_item(mk(pcl_pkg::CMD_QUERY, 0, 32800, 32768, 32768, 0, -1));
    send_item(mk(pcl_pkg::CMD_HEAD, cell_of(16'd32768, 16'd32768, 16'd32768), 0, 0, 0, -1, 0));
    wait_idle();
  endtask

  // well-formed list building and nearby queries, with noise, over several settings
  task automatic test_random();
    logic [31:0] rads [4];
    logic [5:0] mhs [4];
    int p, q, cel, roll;
    logic [15:0] x, y, z;
    rads = '{32'd16777216, RAD_MAX, 32'd268435456, $urandom};
    mhs = '{6'd63, 6'd4, 6'(1 + $urandom_range(0, 62)), 6'd1};
    for (int ph = 0; ph < 4; ph++) begin
      set_config(rads[ph], mhs[ph]);
      for (int k = 0; k < 28; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          do p = $urandom_range(0, NPART - 1); while (mdl_written[p]);
          x = 16'($urandom);
          y = 16'($urandom);
          z = 16'($urandom);
          cel = cell_of(x, y, z);
          send_item(mk(pcl_pkg::CMD_PARTICLE, p, x, y, z, mdl_head[cel], $urandom));
          send_item(mk(pcl_pkg::CMD_HEAD, cel, $urandom, $urandom, $urandom, p, $urandom));
        end else if (roll < 88) begin
          do q = $urandom_range(0, NPART - 1); while (!mdl_written[q]);
          x = 16'(mdl_pos[q][0] + $urandom_range(0, 8191) - 4096);
          y = 16'(mdl_pos[q][1] + $urandom_range(0, 8191) - 4096);
          z = 16'(mdl_pos[q][2] + $urandom_range(0, 8191) - 4096);
          send_item(mk(pcl_pkg::CMD_QUERY, $urandom, x, y, z, $urandom,
                       ($urandom_range(0, 1) ? -1 : $urandom_range(0, 1023))));
        end else if (roll < 93) begin
          send_item(mk(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        end else if (roll < 97) begin
          send_item(mk(pcl_pkg::CMD_PARTICLE, $urandom_range(NPART, 4095), $urandom, $urandom,
                       $urandom, $urandom, $urandom));
        end else begin
          do q = $urandom_range(0, NPART - 1); while (!mdl_written[q]);
          send_item(mk(pcl_pkg::CMD_HEAD, $urandom_range(0, NCELL - 1), 0, 0, 0,
                       ($urandom_range(0, 1) ? -1 : q), 0));
        end
      end
    end
    wait_idle();
  endtask

  // result checker
  always @(posedge clk) begin
    nbr_res_t e;
    if (!rst && strobe) begin
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat status %0d particle %0d", status, particle));
      end else begin
        e = expected_q.pop_front();
        if (status !== e.st) report($sformatf("status %0d want %0d", status, e.st));
        if (particle !== e.part) report($sformatf("particle %0d want %0d", particle, e.part));
        if (dist_sq !== e.d2) report($sformatf("dist_sq %0d want %0d", dist_sq, e.d2));
        if (hit_count !== e.cnt) report($sformatf("hit_count %0d want %0d", hit_count, e.cnt));
        if (last !== e.lst) report($sformatf("last %0b want %0b", last, e.lst));
        if (e.st == pcl_pkg::STAT_HIT) n_hits++;
        if (e.st == pcl_pkg::STAT_OVERFLOW) n_overflow++;
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (psel && penable)) begin
      wd_count <= 0;
    end else begin
      wd_count <= wd_count + 1;
      if (wd_count >= LIMIT) begin
        $display("timeout: no activity for %0d cycles", LIMIT);
        $display("tb_periodic_cell_list_neighbor_search: errors");
        $finish;
      end
    end
  end

  initial begin
    mdl_radius = '0;
    mdl_max_hits = pcl_pkg::MAX_HITS_RST;
    foreach (mdl_head[i]) mdl_head[i] = -11'sd1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    if (expected_q.size() != 0) report($sformatf("%0d beats never came", expected_q.size()));
    $display("covered %0d commands, %0d queries, %0d hit beats, %0d overflows",
             n_items, n_queries, n_hits, n_overflow);
    if (errors == 0) begin
      $display("tb_periodic_cell_list_neighbor_search: clean");
    end else begin
      $display("tb_periodic_cell_list_neighbor_search: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pcl_pkg.sv
rtl/core/pcl_ram.sv
rtl/core/periodic_cell_list_neighbor_search.sv
rtl/core/pcl_check.sv
tb/tb_periodic_cell_list_neighbor_search.sv
